### hw/rtl/fss_pkg.sv
// Shared types and constants of the failover selector.
// No dependencies.
`default_nettype none

package fss_pkg;

    localparam int REG_W     = 20;
    localparam int PAYLOAD_W = 64;
    localparam int FLAGS_W   = 4;
    localparam int MODE_W    = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_INIT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BOTH     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RECOVER  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MAIN_BAD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEC_BAD  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd5;

    localparam logic [1:0] REG_IDX_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_IDX_HYST    = 2'd1;
    localparam logic [1:0] REG_IDX_INIT    = 2'd2;

    localparam logic [REG_W-1:0] TIMEOUT_RST = 20'd100;
    localparam logic [REG_W-1:0] HYST_RST    = 20'd100;
    localparam logic [REG_W-1:0] INIT_RST    = 20'd1000;

    localparam logic [FLAGS_W-1:0] FLAGS_ALL = 4'hF;

    typedef struct packed {
        logic                 main_new;
        logic [FLAGS_W-1:0]   main_flags;
        logic [PAYLOAD_W-1:0] main_payload;
        logic                 secondary_new;
        logic [FLAGS_W-1:0]   secondary_flags;
        logic [PAYLOAD_W-1:0] secondary_payload;
    } t_item;

    typedef struct packed {
        logic                 forward_valid;
        logic [PAYLOAD_W-1:0] forward_payload;
        logic                 from_secondary;
        logic [MODE_W-1:0]    mode;
        logic                 fault;
    } t_result;

    typedef struct packed {
        logic [REG_W-1:0] source_timeout;
        logic [REG_W-1:0] recovery_hyst;
        logic [REG_W-1:0] init_window;
        logic             init_load;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/redundant_source_failover_selector_core.sv
// Top level of the failover selector: stream ports, input and result registers.
// Depends on fss_pkg, fss_cfg and fss_engine.
//
// Usage: each transfer on the s_ channel is one update tick carrying an
// optional main and secondary sample. Every tick yields exactly one result on
// the m_ channel: the selected sample (if any), the failover mode and the
// sticky fault flag. The user must write registers over the APB port only
// while idle; the block does not enforce it. A tick passes the input register,
// then the result register. Throughput: one tick per cycle while m_tready is
// high; the failover state update is one pass of logic between the registers.
// Backpressure: while m_tready is low, the result register holds and one more
// tick waits in the input register; s_tready drops only when both are full.
// Reset: synchronous active-low; both registers empty, mode init, watchdogs
// expired, init window reloaded from its register's reset value.
// Once fault is reached, every later tick returns mode fault with no
// forward until reset.
`default_nettype none

module redundant_source_failover_selector_core
    import fss_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 20
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // main_new, main_flags[4], main_payload[64], secondary_new,
    // secondary_flags[4], secondary_payload[64], zero fill
    input  wire logic [143:0]          s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // forward_valid, forward_payload[64], mode[3], fault, zero fill
    output logic      [71:0]           m_tdata,
    // from_secondary
    output logic                       m_tuser,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg    cfg;
    t_item   in_item;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;

    fss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fss_engine #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (result)
    );

    always_comb begin
        in_item.main_new          = s_tdata[0];
        in_item.main_flags        = s_tdata[4:1];
        in_item.main_payload      = s_tdata[68:5];
        in_item.secondary_new     = s_tdata[69];
        in_item.secondary_flags   = s_tdata[73:70];
        in_item.secondary_payload = s_tdata[137:74];
    end

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_item <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_out.fault, r_out.mode, r_out.forward_payload,
                       r_out.forward_valid};
    assign m_tuser  = r_out.from_secondary;

`ifndef SYNTHESIS
    a_fault_in_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fault) |-> (r_out.mode == MODE_FAULT))
        else $error("fault result without fault mode");

    a_idle_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.forward_valid) |-> (r_out.forward_payload == '0))
        else $error("payload set without forward");

    a_sec_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.from_secondary) |-> r_out.forward_valid)
        else $error("secondary flag without forward");
`endif

endmodule

`default_nettype wire

### hw/rtl/fss_cfg.sv
// APB register file: source timeout, recovery hysteresis, init window.
// Depends on fss_pkg.
`default_nettype none

module fss_cfg
    import fss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic [REG_W-1:0] r_timeout;
    logic [REG_W-1:0] r_hyst;
    logic [REG_W-1:0] r_init;
    logic             r_init_load;
    logic             wr_en;
    logic [1:0]       idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_hyst      <= HYST_RST;
            r_init      <= INIT_RST;
            r_init_load <= 1'b0;
        end else begin
            r_init_load <= 1'b0;
            if (wr_en) begin
                case (idx)
                    REG_IDX_TIMEOUT: r_timeout <= pwdata[REG_W-1:0];
                    REG_IDX_HYST:    r_hyst    <= pwdata[REG_W-1:0];
                    REG_IDX_INIT: begin
                        r_init      <= pwdata[REG_W-1:0];
                        r_init_load <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (idx)
            REG_IDX_TIMEOUT: prdata = APB_DATA_W'(r_timeout);
            REG_IDX_HYST:    prdata = APB_DATA_W'(r_hyst);
            REG_IDX_INIT:    prdata = APB_DATA_W'(r_init);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.source_timeout = r_timeout;
    assign o_cfg.recovery_hyst  = r_hyst;
    assign o_cfg.init_window    = r_init;
    assign o_cfg.init_load      = r_init_load;

endmodule

`default_nettype wire

### hw/rtl/fss_engine.sv
// Failover state machine, source watchdogs, hysteresis and init window counters.
// Depends on fss_pkg.
`default_nettype none

module fss_engine
    import fss_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 20
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_advance,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int TCB   = TICK_COUNT_BITS;
    localparam int SAT_W = (TCB > REG_W) ? TCB : REG_W;
    localparam logic [SAT_W-1:0] CNT_MAX = SAT_W'({TCB{1'b1}});

    function automatic logic [TCB-1:0] f_sat(input logic [REG_W-1:0] v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > CNT_MAX) begin
            f_sat = '1;
        end else begin
            f_sat = w[TCB-1:0];
        end
    endfunction

    function automatic logic [TCB-1:0] f_dec(input logic [TCB-1:0] v);
        f_dec = (v != '0) ? v - TCB'(1) : v;
    endfunction

    logic [MODE_W-1:0] r_mode, n_mode;
    logic [TCB-1:0]    r_main_rem, n_main_rem;
    logic [TCB-1:0]    r_sec_rem, n_sec_rem;
    logic [TCB:0]      r_hyst_rem, n_hyst_rem;
    logic              r_hyst_armed, n_hyst_armed;
    logic [TCB-1:0]    r_init_rem, n_init_rem;
    logic              r_fault, n_fault;

    logic              main_ok, sec_ok, in_init, mv, sv, halted;
    logic [TCB-1:0]    main_cnt, sec_cnt;
    logic [TCB:0]      hyst_cnt;
    logic              armed;
    logic [MODE_W-1:0] nxt;

    always_comb begin
        halted  = r_fault || (r_mode == MODE_FAULT);
        main_ok = i_item.main_new && (i_item.main_flags == FLAGS_ALL);
        sec_ok  = i_item.secondary_new && (i_item.secondary_flags == FLAGS_ALL);
        main_cnt = main_ok ? f_sat(i_cfg.source_timeout) : r_main_rem;
        sec_cnt  = sec_ok ? f_sat(i_cfg.source_timeout) : r_sec_rem;
        mv = (main_cnt != '0);
        sv = (sec_cnt != '0);

        hyst_cnt = r_hyst_rem;
        armed    = r_hyst_armed;
        if (r_mode == MODE_RECOVER) begin
            if (!r_hyst_armed) begin
                hyst_cnt = {1'b0, f_sat(i_cfg.recovery_hyst)} + (TCB+1)'(1);
                armed    = 1'b1;
            end
        end else if (r_mode == MODE_BOTH || r_mode == MODE_MAIN_BAD ||
                     r_mode == MODE_SEC_BAD) begin
            hyst_cnt = '0;
            armed    = 1'b0;
        end

        in_init = (r_mode == MODE_INIT) && (r_init_rem != '0);

        if (!in_init && !mv && !sv) begin
            nxt = MODE_FAULT;
        end else begin
            case (r_mode)
                MODE_INIT: begin
                    if (in_init)  nxt = (mv && sv) ? MODE_BOTH : MODE_INIT;
                    else if (!mv) nxt = MODE_MAIN_BAD;
                    else if (!sv) nxt = MODE_SEC_BAD;
                    else          nxt = MODE_BOTH;
                end
                MODE_BOTH: begin
                    if (!mv)      nxt = MODE_MAIN_BAD;
                    else if (!sv) nxt = MODE_SEC_BAD;
                    else          nxt = MODE_BOTH;
                end
                MODE_RECOVER: begin
                    if (!mv)                  nxt = MODE_MAIN_BAD;
                    else if (!sv)             nxt = MODE_SEC_BAD;
                    else if (hyst_cnt == '0)  nxt = MODE_BOTH;
                    else                      nxt = MODE_RECOVER;
                end
                MODE_MAIN_BAD: nxt = mv ? MODE_RECOVER : MODE_MAIN_BAD;
                MODE_SEC_BAD:  nxt = sv ? MODE_BOTH : MODE_SEC_BAD;
                MODE_FAULT:    nxt = MODE_FAULT;
                default:       nxt = r_mode;
            endcase
        end

        o_result.forward_valid   = 1'b0;
        o_result.forward_payload = '0;
        o_result.from_secondary  = 1'b0;
        if ((nxt == MODE_BOTH || nxt == MODE_SEC_BAD) && main_ok) begin
            o_result.forward_valid   = 1'b1;
            o_result.forward_payload = i_item.main_payload;
        end else if ((nxt == MODE_MAIN_BAD || nxt == MODE_RECOVER) && sec_ok) begin
            o_result.forward_valid   = 1'b1;
            o_result.forward_payload = i_item.secondary_payload;
            o_result.from_secondary  = 1'b1;
        end
        o_result.mode  = nxt;
        o_result.fault = (nxt == MODE_FAULT);

        n_mode       = nxt;
        n_fault      = (nxt == MODE_FAULT);
        n_main_rem   = f_dec(main_cnt);
        n_sec_rem    = f_dec(sec_cnt);
        n_hyst_rem   = (hyst_cnt != '0) ? hyst_cnt - (TCB+1)'(1) : hyst_cnt;
        n_hyst_armed = armed;
        n_init_rem   = f_dec(r_init_rem);

        // latched fault: item is swallowed, counters hold
        if (halted) begin
            o_result       = '0;
            o_result.mode  = MODE_FAULT;
            o_result.fault = 1'b1;
            n_mode       = MODE_FAULT;
            n_fault      = 1'b1;
            n_main_rem   = r_main_rem;
            n_sec_rem    = r_sec_rem;
            n_hyst_rem   = r_hyst_rem;
            n_hyst_armed = r_hyst_armed;
            n_init_rem   = r_init_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_INIT;
            r_main_rem   <= '0;
            r_sec_rem    <= '0;
            r_hyst_rem   <= '0;
            r_hyst_armed <= 1'b0;
            r_init_rem   <= f_sat(INIT_RST);
            r_fault      <= 1'b0;
        end else if (i_cfg.init_load) begin
            r_init_rem <= f_sat(i_cfg.init_window);
        end else if (i_advance) begin
            r_mode       <= n_mode;
            r_main_rem   <= n_main_rem;
            r_sec_rem    <= n_sec_rem;
            r_hyst_rem   <= n_hyst_rem;
            r_hyst_armed <= n_hyst_armed;
            r_init_rem   <= n_init_rem;
            r_fault      <= n_fault;
        end
    end

`ifndef SYNTHESIS
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("fault flag dropped");

    a_fault_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |-> (r_mode == MODE_FAULT))
        else $error("fault latched outside fault mode");

    a_init_unarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_INIT) |-> !r_hyst_armed)
        else $error("hysteresis armed during init");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for redundant_source_failover_selector_core: stream ticks in,
// one result per tick out, APB register writes between phases.
// Depends on fss_pkg and the core RTL only.
`default_nettype none

module testbench
    import fss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam logic [1:0] REG_IDX_NONE = 2'd3;
    localparam logic [PAYLOAD_W-1:0] ONES64 = {PAYLOAD_W{1'b1}};
    localparam logic [REG_W-1:0] REG_MAX = {REG_W{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [143:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic m_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    redundant_source_failover_selector_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted selector state
    logic [REG_W-1:0]  p_timeout   = TIMEOUT_RST;
    logic [REG_W-1:0]  p_hyst      = HYST_RST;
    logic [MODE_W-1:0] p_mode      = MODE_INIT;
    logic [REG_W-1:0]  p_main_left = '0;
    logic [REG_W-1:0]  p_sec_left  = '0;
    logic [REG_W:0]    p_hyst_left = '0;
    logic              p_hyst_armed = 1'b0;
    logic [REG_W-1:0]  p_init_left = INIT_RST;
    logic              p_fault     = 1'b0;

    t_item   pending_ticks[$];
    t_result expected_results[$];
    t_item   drv_item;

    // stimulus-side watchdog mirror, keeps at least one source alive while g_guard is set
    int g_timeout = 100;
    int g_main_left = 0;
    int g_sec_left = 0;
    int g_main_out = 0;
    int g_sec_out = 0;
    bit g_guard = 1'b0;

    int mismatches = 0;
    int items_taken = 0;
    int cycles = 0;
    int stall_left = 0;
    int stall_mark = -1;
    bit stall_used = 1'b0;
    bit quiet = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_item mk(int mn, logic [3:0] mf, logic [63:0] mp,
                                 int sn, logic [3:0] sf, logic [63:0] sp);
        t_item it;
        it.main_new = 1'(mn);
        it.main_flags = mf;
        it.main_payload = mp;
        it.secondary_new = 1'(sn);
        it.secondary_flags = sf;
        it.secondary_payload = sp;
        return it;
    endfunction

    function automatic logic [143:0] pack_tick(t_item it);
        return {6'b0, it.secondary_payload, it.secondary_flags, it.secondary_new,
                it.main_payload, it.main_flags, it.main_new};
    endfunction

    task automatic step_failover(input t_item it);
        t_result r;
        logic m_ok, s_ok, win, mv, sv;
        logic [MODE_W-1:0] nx;
        r = '0;
        if (p_fault || p_mode == MODE_FAULT) begin
            p_fault = 1'b1;
            p_mode = MODE_FAULT;
            r.mode = MODE_FAULT;
            r.fault = 1'b1;
        end else begin
            m_ok = it.main_new && (it.main_flags == FLAGS_ALL);
            s_ok = it.secondary_new && (it.secondary_flags == FLAGS_ALL);
            if (m_ok) p_main_left = p_timeout;
            if (s_ok) p_sec_left = p_timeout;
            if (p_mode == MODE_RECOVER) begin
                if (!p_hyst_armed) begin
                    p_hyst_left = {1'b0, p_hyst} + (REG_W+1)'(1);
                    p_hyst_armed = 1'b1;
                end
            end else if (p_mode == MODE_BOTH || p_mode == MODE_MAIN_BAD ||
                         p_mode == MODE_SEC_BAD) begin
                p_hyst_armed = 1'b0;
                p_hyst_left = '0;
            end
            win = (p_mode == MODE_INIT) && (p_init_left != 0);
            mv = p_main_left != 0;
            sv = p_sec_left != 0;
            if (!win && !mv && !sv) begin
                nx = MODE_FAULT;
            end else begin
                case (p_mode)
                    MODE_INIT: begin
                        if (win) nx = (mv && sv) ? MODE_BOTH : MODE_INIT;
                        else if (!mv) nx = MODE_MAIN_BAD;
                        else if (!sv) nx = MODE_SEC_BAD;
                        else nx = MODE_BOTH;
                    end
                    MODE_BOTH: begin
                        if (!mv) nx = MODE_MAIN_BAD;
                        else if (!sv) nx = MODE_SEC_BAD;
                        else nx = MODE_BOTH;
                    end
                    MODE_RECOVER: begin
                        if (!mv) nx = MODE_MAIN_BAD;
                        else if (!sv) nx = MODE_SEC_BAD;
                        else if (p_hyst_left == 0) nx = MODE_BOTH;
                        else nx = MODE_RECOVER;
                    end
                    MODE_MAIN_BAD: nx = mv ? MODE_RECOVER : MODE_MAIN_BAD;
                    MODE_SEC_BAD:  nx = sv ? MODE_BOTH : MODE_SEC_BAD;
                    default:       nx = p_mode;
                endcase
            end
            if (nx == MODE_FAULT) begin
                p_fault = 1'b1;
            end else if (nx == MODE_BOTH || nx == MODE_SEC_BAD) begin
                if (m_ok) begin
                    r.forward_valid = 1'b1;
                    r.forward_payload = it.main_payload;
                end
            end else if (nx == MODE_MAIN_BAD || nx == MODE_RECOVER) begin
                if (s_ok) begin
                    r.forward_valid = 1'b1;
                    r.forward_payload = it.secondary_payload;
                    r.from_secondary = 1'b1;
                end
            end
            p_mode = nx;
            if (p_main_left != 0) p_main_left = p_main_left - REG_W'(1);
            if (p_sec_left != 0) p_sec_left = p_sec_left - REG_W'(1);
            if (p_hyst_left != 0) p_hyst_left = p_hyst_left - (REG_W+1)'(1);
            if (p_init_left != 0) p_init_left = p_init_left - REG_W'(1);
            r.mode = p_mode;
            r.fault = p_fault;
        end
        expected_results.push_back(r);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%s mismatch: expected %h, got %h", name, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_failover(drv_item);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
                    drv_item = pending_ticks.pop_front();
                    s_tdata <= pack_tick(drv_item);
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (!stall_used && stall_mark >= 0 && items_taken >= stall_mark) begin
            stall_left <= 300;
            stall_used <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result transfer with none expected: %h", m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("forward_valid", 64'(want.forward_valid), 64'(m_tdata[0]));
                    check_field("forward_payload", want.forward_payload, m_tdata[64:1]);
                    check_field("from_secondary", 64'(want.from_secondary), 64'(m_tuser));
                    check_field("mode", 64'(want.mode), 64'(m_tdata[67:65]));
                    check_field("fault", 64'(want.fault), 64'(m_tdata[68]));
                end
            end
            m_tready <= (stall_left == 0) && (quiet || $urandom_range(0, 99) >= 15);
        end
    end

    task automatic set_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_IDX_TIMEOUT) begin
            p_timeout = val;
            g_timeout = int'(val);
        end else if (idx == REG_IDX_HYST) begin
            p_hyst = val;
        end else if (idx == REG_IDX_INIT) begin
            p_init_left = val;
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_tick(input t_item it);
        logic m_ok, s_ok;
        m_ok = it.main_new && (it.main_flags == FLAGS_ALL);
        s_ok = it.secondary_new && (it.secondary_flags == FLAGS_ALL);
        if (g_guard && !m_ok && !s_ok && g_main_left == 0 && g_sec_left == 0) begin
            if ($urandom_range(0, 1)) begin
                it.main_new = 1'b1;
                it.main_flags = FLAGS_ALL;
                m_ok = 1'b1;
            end else begin
                it.secondary_new = 1'b1;
                it.secondary_flags = FLAGS_ALL;
                s_ok = 1'b1;
            end
        end
        if (m_ok) g_main_left = g_timeout;
        if (s_ok) g_sec_left = g_timeout;
        if (g_main_left != 0) g_main_left--;
        if (g_sec_left != 0) g_sec_left--;
        pending_ticks.push_back(it);
    endtask

    // mostly good samples, with outages of either source that can be long enough
    // to run its watchdog down
    task automatic queue_random(input int n);
        t_item it;
        int olen;
        bit mg, sg;
        for (int k = 0; k < n; k++) begin
            olen = (g_timeout > 28) ? 60 : 2 * g_timeout + 4;
            if (g_main_out > 0) begin
                g_main_out--;
                mg = 1'b0;
            end else if ($urandom_range(0, 99) < 4) begin
                g_main_out = $urandom_range(1, olen);
                mg = 1'b0;
            end else begin
                mg = $urandom_range(0, 99) < 75;
            end
            if (g_sec_out > 0) begin
                g_sec_out--;
                sg = 1'b0;
            end else if ($urandom_range(0, 99) < 4) begin
                g_sec_out = $urandom_range(1, olen);
                sg = 1'b0;
            end else begin
                sg = $urandom_range(0, 99) < 65;
            end
            it.main_new = mg ? 1'b1 : 1'($urandom_range(0, 1));
            it.main_flags = mg ? FLAGS_ALL :
                (it.main_new ? 4'($urandom_range(0, 14)) : 4'($urandom_range(0, 15)));
            it.main_payload = r64();
            it.secondary_new = sg ? 1'b1 : 1'($urandom_range(0, 1));
            it.secondary_flags = sg ? FLAGS_ALL :
                (it.secondary_new ? 4'($urandom_range(0, 14)) : 4'($urandom_range(0, 15)));
            it.secondary_payload = r64();
            queue_tick(it);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero timeout inside a wide-open init window: nothing ever becomes valid
        set_reg(REG_IDX_TIMEOUT, '0);
        set_reg(REG_IDX_INIT, REG_MAX);
        for (int k = 0; k < 5; k++) queue_tick(mk(1, FLAGS_ALL, r64(), 1, FLAGS_ALL, r64()));
        queue_tick(mk(0, 4'h0, '0, 0, 4'h0, '0));
        queue_tick(mk(1, FLAGS_ALL, ONES64, 1, FLAGS_ALL, ONES64));
        queue_tick(mk(1, FLAGS_ALL, '0, 0, FLAGS_ALL, r64()));
        wait_idle();

        // window closed at once; walk through every failover mode except fault
        set_reg(REG_IDX_TIMEOUT, 20'd3);
        set_reg(REG_IDX_HYST, 20'd2);
        set_reg(REG_IDX_INIT, '0);
        set_reg(REG_IDX_NONE, REG_MAX);
        g_guard = 1'b1;
        queue_tick(mk(1, FLAGS_ALL, ONES64, 0, 4'h0, '0));
        queue_tick(mk(1, FLAGS_ALL, '0, 1, FLAGS_ALL, ONES64));
        queue_tick(mk(1, 4'h7, r64(), 1, FLAGS_ALL, r64()));
        queue_tick(mk(0, FLAGS_ALL, r64(), 1, FLAGS_ALL, r64()));
        queue_tick(mk(1, 4'hE, r64(), 1, FLAGS_ALL, r64()));
        for (int k = 0; k < 5; k++) queue_tick(mk(1, FLAGS_ALL, r64(), 1, FLAGS_ALL, r64()));
        queue_tick(mk(1, FLAGS_ALL, r64(), 1, 4'hB, r64()));
        for (int k = 0; k < 3; k++) queue_tick(mk(1, FLAGS_ALL, r64(), 0, FLAGS_ALL, r64()));
        queue_tick(mk(1, FLAGS_ALL, r64(), 1, 4'hD, r64()));
        queue_tick(mk(1, FLAGS_ALL, r64(), 1, FLAGS_ALL, r64()));
        for (int k = 0; k < 3; k++) queue_tick(mk(0, 4'h0, r64(), 1, FLAGS_ALL, r64()));
        queue_tick(mk(1, FLAGS_ALL, r64(), 1, FLAGS_ALL, r64()));
        for (int k = 0; k < 3; k++) queue_tick(mk(1, 4'h8, r64(), 1, FLAGS_ALL, r64()));
        wait_idle();

        set_reg(REG_IDX_TIMEOUT, 20'd12);
        set_reg(REG_IDX_HYST, 20'd6);
        set_reg(REG_IDX_INIT, 20'd500);
        queue_random(350);
        wait_idle();

        quiet = 1'b1;
        set_reg(REG_IDX_TIMEOUT, 20'd1);
        set_reg(REG_IDX_HYST, '0);
        queue_random(150);
        wait_idle();
        quiet = 1'b0;

        set_reg(REG_IDX_TIMEOUT, 20'd30);
        set_reg(REG_IDX_HYST, 20'd20);
        stall_mark = items_taken + 20;
        queue_random(300);
        wait_idle();

        set_reg(REG_IDX_TIMEOUT, REG_MAX);
        set_reg(REG_IDX_HYST, REG_MAX);
        set_reg(REG_IDX_INIT, REG_MAX);
        queue_random(60);
        wait_idle();

        set_reg(REG_IDX_TIMEOUT, 20'd4);
        set_reg(REG_IDX_HYST, 20'd3);
        set_reg(REG_IDX_INIT, '0);
        queue_random(250);
        wait_idle();

        // let both watchdogs run out; fault is sticky from here on
        set_reg(REG_IDX_TIMEOUT, 20'd2);
        g_guard = 1'b0;
        for (int k = 0; k < 6; k++) queue_tick(mk(0, FLAGS_ALL, r64(), 1, 4'h3, r64()));
        queue_random(30);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/fss_pkg.sv
hw/rtl/fss_cfg.sv
hw/rtl/fss_engine.sv
hw/rtl/redundant_source_failover_selector_core.sv
tb/testbench.sv
